// ===== rtl/arrh_pkg.sv =====
// Shared widths, codes, pipeline context types and helpers for the rectangle hit tester.
package arrh_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int TEX_W       = 17;
  localparam int MAT_W       = 8;
  localparam int ADDR_W      = 5;
  // (k - o) magnitude is 33 bits, scaled by 2^F
  localparam int NUM_W       = 33 + FRAC_BITS;
  // t must fit 32 bits to pass the interval test
  localparam int TDIV_STEPS  = 32;
  // normalized coordinate is at most 1.0, so F+1 quotient bits
  localparam int NDIV_STEPS  = FRAC_BITS + 1;
  // origin + floor(t*d / 2^F) at full precision
  localparam int PW          = 65 - FRAC_BITS;

  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;
  localparam logic [1:0] PLANE_ZX = 2'd2;

  localparam logic [2:0] REG_PLANE_AXIS   = 3'd0;
  localparam logic [2:0] REG_PLANE_OFFSET = 3'd1;
  localparam logic [2:0] REG_U_LOW        = 3'd2;
  localparam logic [2:0] REG_U_HIGH       = 3'd3;
  localparam logic [2:0] REG_V_LOW        = 3'd4;
  localparam logic [2:0] REG_V_HIGH       = 3'd5;
  localparam logic [2:0] REG_MATERIAL_ID  = 3'd6;

  localparam logic signed [DATA_W-1:0] FIX_ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // ray context carried through the t divider
  typedef struct packed {
    logic signed [DATA_W-1:0] ox;
    logic signed [DATA_W-1:0] oy;
    logic signed [DATA_W-1:0] oz;
    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [DATA_W-1:0] dz;
    logic signed [DATA_W-1:0] tlo;
    logic signed [DATA_W-1:0] thi;
    logic                     front;
    logic                     neg;
    logic                     miss;
  } ray_ctx_t;

  // result context carried through the u/v dividers
  typedef struct packed {
    logic                     miss;
    logic                     front;
    logic                     zu;
    logic                     zv;
    logic        [DATA_W-1:0] span_u;
    logic        [DATA_W-1:0] span_v;
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
    logic signed [DATA_W-1:0] pz;
  } hit_ctx_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PW-1:0] p);
    logic signed [DATA_W-1:0] r;
    if (p > PW'(S32_MAX)) begin
      r = S32_MAX;
    end else if (p < PW'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = p[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/arrh_if.sv =====
// Ray input and hit result channel interfaces.
interface arrh_ray_if import arrh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] origin_x;
  logic signed [DATA_W-1:0] origin_y;
  logic signed [DATA_W-1:0] origin_z;
  logic signed [DATA_W-1:0] dir_x;
  logic signed [DATA_W-1:0] dir_y;
  logic signed [DATA_W-1:0] dir_z;
  logic signed [DATA_W-1:0] t_lower;
  logic signed [DATA_W-1:0] t_upper;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  t_lower, t_upper, input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                t_lower, t_upper, output ready);
endinterface

interface arrh_hit_if import arrh_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit_found;
  logic signed [DATA_W-1:0] hit_t;
  logic        [TEX_W-1:0]  tex_u;
  logic        [TEX_W-1:0]  tex_v;
  logic signed [DATA_W-1:0] point_x;
  logic signed [DATA_W-1:0] point_y;
  logic signed [DATA_W-1:0] point_z;
  logic                     front_face;
  logic        [MAT_W-1:0]  hit_material;

  modport source (output valid, hit_found, hit_t, tex_u, tex_v, point_x, point_y, point_z,
                  front_face, hit_material, input ready);
  modport sink (input valid, hit_found, hit_t, tex_u, tex_v, point_x, point_y, point_z,
                front_face, hit_material, output ready);
endinterface

// ===== rtl/axis_aligned_rect_ray_hit.sv =====
// Top level: pipelined ray versus axis-aligned rectangle hit test with APB registers.
// Pipeline stages from input beat to result beat:
//   input stage, 32 t-divider steps, 4 arithmetic stages, FRAC_BITS+1 u/v divider steps,
//   output register. The restoring dividers retire one quotient bit per stage.
// Throughput: one ray per cycle; a stalled output freezes the pipe, an empty input
//   stage still takes a beat. Reset clears valid bits and loads register defaults.
module axis_aligned_rect_ray_hit import arrh_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  arrh_ray_if.sink          ray,
  arrh_hit_if.source        hit
);

  // ---------------- registers ----------------
  logic        [1:0]        plane_axis;
  logic signed [DATA_W-1:0] plane_offset;
  logic signed [DATA_W-1:0] u_low;
  logic signed [DATA_W-1:0] u_high;
  logic signed [DATA_W-1:0] v_low;
  logic signed [DATA_W-1:0] v_high;
  logic        [MAT_W-1:0]  material_id;
  logic                     cfg_wr;
  logic        [2:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_axis   <= PLANE_XY;
      plane_offset <= '0;
      u_low        <= '0;
      u_high       <= FIX_ONE;
      v_low        <= '0;
      v_high       <= FIX_ONE;
      material_id  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_PLANE_AXIS:   plane_axis   <= pwdata[1:0];
        REG_PLANE_OFFSET: plane_offset <= pwdata;
        REG_U_LOW:        u_low        <= pwdata;
        REG_U_HIGH:       u_high       <= pwdata;
        REG_V_LOW:        v_low        <= pwdata;
        REG_V_HIGH:       v_high       <= pwdata;
        REG_MATERIAL_ID:  material_id  <= pwdata[MAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PLANE_AXIS:   prdata = DATA_W'(plane_axis);
      REG_PLANE_OFFSET: prdata = plane_offset;
      REG_U_LOW:        prdata = u_low;
      REG_U_HIGH:       prdata = u_high;
      REG_V_LOW:        prdata = v_low;
      REG_V_HIGH:       prdata = v_high;
      REG_MATERIAL_ID:  prdata = DATA_W'(material_id);
      default:          prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic en;
  logic load0;
  logic s0_v;

  assign en        = !hit.valid || hit.ready;
  assign load0     = en || !s0_v;
  assign ray.ready = load0;

  // ---------------- input stage ----------------
  logic signed [DATA_W-1:0] oa;
  logic signed [DATA_W-1:0] da;
  logic                     axis_bad;
  logic signed [32:0]       diff;
  logic        [32:0]       mag;
  logic        [DATA_W-1:0] dmag;
  ray_ctx_t                 c0;
  ray_ctx_t                 s0_c;
  logic        [32:0]       s0_mag;
  logic        [DATA_W-1:0] s0_dm;

  always_comb begin
    axis_bad = 1'b0;
    unique case (plane_axis)
      PLANE_XY: begin oa = ray.origin_z; da = ray.dir_z; end
      PLANE_YZ: begin oa = ray.origin_x; da = ray.dir_x; end
      PLANE_ZX: begin oa = ray.origin_y; da = ray.dir_y; end
      default: begin
        oa = ray.origin_x;
        da = ray.dir_x;
        axis_bad = 1'b1;
      end
    endcase
    diff = $signed({plane_offset[DATA_W-1], plane_offset}) - $signed({oa[DATA_W-1], oa});
    mag  = diff[32] ? 33'(-diff) : diff;
    dmag = da[DATA_W-1] ? DATA_W'(-da) : da;
    c0.ox    = ray.origin_x;
    c0.oy    = ray.origin_y;
    c0.oz    = ray.origin_z;
    c0.dx    = ray.dir_x;
    c0.dy    = ray.dir_y;
    c0.dz    = ray.dir_z;
    c0.tlo   = ray.t_lower;
    c0.thi   = ray.t_upper;
    c0.front = da[DATA_W-1];
    c0.neg   = diff[32] ^ da[DATA_W-1];
    c0.miss  = axis_bad || (da == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (load0) begin
      s0_v <= ray.valid;
    end
    if (load0) begin
      s0_c   <= c0;
      s0_mag <= mag;
      s0_dm  <= dmag;
    end
  end

  // ---------------- t divider: |k - o| * 2^F / |d| ----------------
  logic                     tdv [0:TDIV_STEPS];
  logic        [DATA_W-1:0] tdp [0:TDIV_STEPS];
  logic        [DATA_W-1:0] tdn [0:TDIV_STEPS];
  logic        [DATA_W-1:0] tdq [0:TDIV_STEPS];
  logic        [DATA_W-1:0] tdm [0:TDIV_STEPS];
  ray_ctx_t                 tdc [0:TDIV_STEPS];
  logic        [NUM_W-1:0]  numer;

  always_comb begin
    numer  = {s0_mag, {FRAC_BITS{1'b0}}};
    tdv[0] = s0_v;
    tdp[0] = DATA_W'(numer[NUM_W-1:DATA_W]);
    tdn[0] = numer[DATA_W-1:0];
    tdq[0] = '0;
    tdm[0] = s0_dm;
    tdc[0] = s0_c;
    // quotient would need more than 32 bits: t is outside any 32-bit interval
    tdc[0].miss = s0_c.miss || (tdp[0] >= s0_dm);
  end

  for (genvar k = 0; k < TDIV_STEPS; k++) begin : g_tdiv
    logic [DATA_W:0] trial;
    logic            ge;

    always_comb begin
      trial = {tdp[k], tdn[k][DATA_W-1]};
      ge    = trial >= {1'b0, tdm[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tdv[k+1] <= 1'b0;
      end else if (en) begin
        tdv[k+1] <= tdv[k];
      end
      if (en) begin
        tdp[k+1] <= ge ? DATA_W'(trial - {1'b0, tdm[k]}) : trial[DATA_W-1:0];
        tdn[k+1] <= tdn[k] << 1;
        tdq[k+1] <= {tdq[k][DATA_W-2:0], ge};
        tdm[k+1] <= tdm[k];
        tdc[k+1] <= tdc[k];
      end
    end
  end

  // ---------------- sign and interval test ----------------
  logic signed [33:0]       t_full;
  logic                     t_out;
  logic                     ts_v;
  logic signed [DATA_W-1:0] ts_t;
  ray_ctx_t                 ts_in;
  ray_ctx_t                 ts_c;

  always_comb begin
    t_full = tdc[TDIV_STEPS].neg ? $signed(34'd0 - {2'b00, tdq[TDIV_STEPS]})
                                 : $signed({2'b00, tdq[TDIV_STEPS]});
    t_out  = (t_full < 34'(tdc[TDIV_STEPS].tlo)) || (t_full > 34'(tdc[TDIV_STEPS].thi));
    ts_in      = tdc[TDIV_STEPS];
    ts_in.miss = tdc[TDIV_STEPS].miss || t_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ts_v <= 1'b0;
    end else if (en) begin
      ts_v <= tdv[TDIV_STEPS];
    end
    if (en) begin
      ts_t <= t_full[DATA_W-1:0];
      ts_c <= ts_in;
    end
  end

  // ---------------- t * d per component ----------------
  logic                       mv;
  logic signed [2*DATA_W-1:0] m_px;
  logic signed [2*DATA_W-1:0] m_py;
  logic signed [2*DATA_W-1:0] m_pz;
  logic signed [DATA_W-1:0]   m_t;
  ray_ctx_t                   m_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= ts_v;
    end
    if (en) begin
      m_px <= ts_t * ts_c.dx;
      m_py <= ts_t * ts_c.dy;
      m_pz <= ts_t * ts_c.dz;
      m_t  <= ts_t;
      m_c  <= ts_c;
    end
  end

  // ---------------- hit point at full precision ----------------
  logic                     av;
  logic signed [PW-1:0]     a_px;
  logic signed [PW-1:0]     a_py;
  logic signed [PW-1:0]     a_pz;
  logic signed [DATA_W-1:0] a_t;
  ray_ctx_t                 a_c;

  // arithmetic shift is the floor of the scaled product
  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else if (en) begin
      av <= mv;
    end
    if (en) begin
      a_px <= PW'(m_c.ox) + PW'(m_px >>> FRAC_BITS);
      a_py <= PW'(m_c.oy) + PW'(m_py >>> FRAC_BITS);
      a_pz <= PW'(m_c.oz) + PW'(m_pz >>> FRAC_BITS);
      a_t  <= m_t;
      a_c  <= m_c;
    end
  end

  // ---------------- bounds test, u/v divider setup ----------------
  logic signed [PW-1:0]     pu;
  logic signed [PW-1:0]     pv;
  logic                     b_out;
  logic        [DATA_W-1:0] num_u;
  logic        [DATA_W-1:0] num_v;
  hit_ctx_t                 hc;

  logic                     ndv [0:NDIV_STEPS];
  logic        [DATA_W-1:0] nup [0:NDIV_STEPS];
  logic        [FRAC_BITS:0] nun [0:NDIV_STEPS];
  logic        [FRAC_BITS:0] nuq [0:NDIV_STEPS];
  logic        [DATA_W-1:0] nvp [0:NDIV_STEPS];
  logic        [FRAC_BITS:0] nvn [0:NDIV_STEPS];
  logic        [FRAC_BITS:0] nvq [0:NDIV_STEPS];
  hit_ctx_t                 ndc [0:NDIV_STEPS];

  always_comb begin
    unique case (plane_axis)
      PLANE_YZ: begin pu = a_py; pv = a_pz; end
      PLANE_ZX: begin pu = a_px; pv = a_pz; end
      default:  begin pu = a_px; pv = a_py; end
    endcase
    b_out = (pu < PW'(u_low)) || (pu > PW'(u_high)) ||
            (pv < PW'(v_low)) || (pv > PW'(v_high));
    num_u = DATA_W'(pu - PW'(u_low));
    num_v = DATA_W'(pv - PW'(v_low));
    hc.miss   = a_c.miss || b_out;
    hc.front  = a_c.front;
    hc.zu     = (u_high == u_low);
    hc.zv     = (v_high == v_low);
    hc.span_u = DATA_W'(u_high - u_low);
    hc.span_v = DATA_W'(v_high - v_low);
    hc.t      = a_t;
    hc.px     = sat32(a_px);
    hc.py     = sat32(a_py);
    hc.pz     = sat32(a_pz);
  end

  // numerator num * 2^F: top bits start the remainder, the rest shift in
  always_ff @(posedge clk) begin
    if (rst) begin
      ndv[0] <= 1'b0;
    end else if (en) begin
      ndv[0] <= av;
    end
    if (en) begin
      nup[0] <= num_u >> 1;
      nun[0] <= {num_u[0], {FRAC_BITS{1'b0}}};
      nuq[0] <= '0;
      nvp[0] <= num_v >> 1;
      nvn[0] <= {num_v[0], {FRAC_BITS{1'b0}}};
      nvq[0] <= '0;
      ndc[0] <= hc;
    end
  end

  for (genvar k = 0; k < NDIV_STEPS; k++) begin : g_ndiv
    logic [DATA_W:0] tr_u;
    logic [DATA_W:0] tr_v;
    logic            ge_u;
    logic            ge_v;

    always_comb begin
      tr_u = {nup[k], nun[k][FRAC_BITS]};
      tr_v = {nvp[k], nvn[k][FRAC_BITS]};
      ge_u = tr_u >= {1'b0, ndc[k].span_u};
      ge_v = tr_v >= {1'b0, ndc[k].span_v};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ndv[k+1] <= 1'b0;
      end else if (en) begin
        ndv[k+1] <= ndv[k];
      end
      if (en) begin
        nup[k+1] <= ge_u ? DATA_W'(tr_u - {1'b0, ndc[k].span_u}) : tr_u[DATA_W-1:0];
        nvp[k+1] <= ge_v ? DATA_W'(tr_v - {1'b0, ndc[k].span_v}) : tr_v[DATA_W-1:0];
        nun[k+1] <= nun[k] << 1;
        nvn[k+1] <= nvn[k] << 1;
        nuq[k+1] <= {nuq[k][FRAC_BITS-1:0], ge_u};
        nvq[k+1] <= {nvq[k][FRAC_BITS-1:0], ge_v};
        ndc[k+1] <= ndc[k];
      end
    end
  end

  // ---------------- output register ----------------
  hit_ctx_t fc;
  assign fc = ndc[NDIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      hit.valid <= 1'b0;
    end else if (en) begin
      hit.valid <= ndv[NDIV_STEPS];
    end
    if (en) begin
      if (fc.miss) begin
        hit.hit_found    <= 1'b0;
        hit.hit_t        <= '0;
        hit.tex_u        <= '0;
        hit.tex_v        <= '0;
        hit.point_x      <= '0;
        hit.point_y      <= '0;
        hit.point_z      <= '0;
        hit.front_face   <= 1'b0;
        hit.hit_material <= '0;
      end else begin
        hit.hit_found    <= 1'b1;
        hit.hit_t        <= fc.t;
        // zero-width span: a hit on the bound reads as zero
        hit.tex_u        <= fc.zu ? '0 : TEX_W'(nuq[NDIV_STEPS]);
        hit.tex_v        <= fc.zv ? '0 : TEX_W'(nvq[NDIV_STEPS]);
        hit.point_x      <= fc.px;
        hit.point_y      <= fc.py;
        hit.point_z      <= fc.pz;
        hit.front_face   <= fc.front;
        hit.hit_material <= material_id;
      end
    end
  end

  // ---------------- assertions ----------------
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    hit.valid && !hit.hit_found |->
      hit.hit_t == '0 && hit.tex_u == '0 && hit.tex_v == '0 && hit.point_x == '0 &&
      hit.point_y == '0 && hit.point_z == '0 && !hit.front_face && hit.hit_material == '0)
    else $error("miss beat carries nonzero fields");

  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    en && ndv[NDIV_STEPS] |=> hit.valid)
    else $error("last pipe stage lost on advance");

  a_s0_hold: assert property (@(posedge clk) disable iff (rst)
    !en && s0_v |=> s0_v && $stable(s0_c))
    else $error("input stage dropped under stall");

endmodule

// ===== tb/axis_aligned_rect_ray_hit_tb.sv =====
// Testbench for the ray versus axis-aligned rectangle hit tester.
`timescale 1ns / 100ps

module axis_aligned_rect_ray_hit_tb;
  import arrh_pkg::*;

  typedef struct {
    logic signed [31:0] o [3];
    logic signed [31:0] d [3];
    logic signed [31:0] tlo;
    logic signed [31:0] thi;
  } ray_t;

  typedef struct {
    logic        found;
    logic [31:0] t;
    logic [16:0] u;
    logic [16:0] v;
    logic [31:0] p [3];
    logic        front;
    logic [7:0]  mat;
  } hit_t;

  // register shadow
  logic [1:0]         axis_q;
  logic signed [63:0] offset_q, ulo_q, uhi_q, vlo_q, vhi_q;
  logic [7:0]         mat_q;

  function automatic logic [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [16:0] norm_coord(logic signed [63:0] p, lo, hi);
    logic signed [63:0] span;
    logic [63:0] q;
    span = hi - lo;
    if (span <= 0) return '0;
    q = 64'((p - lo) <<< FRAC_BITS) / 64'(span);
    return q[16:0];
  endfunction

  function automatic hit_t trace_ray(ray_t r);
    hit_t h;
    int a, cu, cv;
    logic signed [63:0] t, pr, pt [3];
    logic signed [127:0] num;
    h.found = 0; h.t = 0; h.u = 0; h.v = 0; h.front = 0; h.mat = 0;
    for (int i = 0; i < 3; i++) h.p[i] = 0;
    case (axis_q)
      PLANE_XY: begin a = 2; cu = 0; cv = 1; end
      PLANE_YZ: begin a = 0; cu = 1; cv = 2; end
      PLANE_ZX: begin a = 1; cu = 0; cv = 2; end
      default: return h;
    endcase
    if (r.d[a] == 0) return h;
    num = 128'(offset_q - 64'(r.o[a])) <<< FRAC_BITS;
    t = 64'(num / 128'(r.d[a]));
    if (t < 64'(r.tlo) || t > 64'(r.thi)) return h;
    for (int i = 0; i < 3; i++) begin
      pr = t * 64'(r.d[i]);
      pt[i] = 64'(r.o[i]) + (pr >>> FRAC_BITS);
    end
    if (pt[cu] < ulo_q || pt[cu] > uhi_q || pt[cv] < vlo_q || pt[cv] > vhi_q) return h;
    h.found = 1;
    h.t = clamp32(t);
    h.u = norm_coord(pt[cu], ulo_q, uhi_q);
    h.v = norm_coord(pt[cv], vlo_q, vhi_q);
    for (int i = 0; i < 3; i++) h.p[i] = clamp32(pt[i]);
    h.front = r.d[a] < 0;
    h.mat = mat_q;
    return h;
  endfunction

  class hit_scoreboard;
    hit_t pending [$];
    int errors;
    function void note_ray(ray_t r);
      pending.push_back(trace_ray(r));
    endfunction
    function void check_hit(hit_t got);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected hit beat", $time);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.found !== e.found) begin
        $display("%0t hit_found exp %0d got %0d", $time, e.found, got.found); errors++;
      end
      if (got.t !== e.t) begin
        $display("%0t hit_t exp %h got %h", $time, e.t, got.t); errors++;
      end
      if (got.u !== e.u) begin
        $display("%0t tex_u exp %h got %h", $time, e.u, got.u); errors++;
      end
      if (got.v !== e.v) begin
        $display("%0t tex_v exp %h got %h", $time, e.v, got.v); errors++;
      end
      for (int i = 0; i < 3; i++)
        if (got.p[i] !== e.p[i]) begin
          $display("%0t point[%0d] exp %h got %h", $time, i, e.p[i], got.p[i]); errors++;
        end
      if (got.front !== e.front) begin
        $display("%0t front_face exp %0d got %0d", $time, e.front, got.front); errors++;
      end
      if (got.mat !== e.mat) begin
        $display("%0t hit_material exp %h got %h", $time, e.mat, got.mat); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  int   cycles = 0;
  hit_scoreboard sb;

  arrh_ray_if ray ();
  arrh_hit_if hit ();

  axis_aligned_rect_ray_hit dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .ray(ray.sink), .hit(hit.source)
  );

  always #4 clk = ~clk;

  initial begin
    ray.valid = 0; ray.origin_x = 0; ray.origin_y = 0; ray.origin_z = 0;
    ray.dir_x = 0; ray.dir_y = 0; ray.dir_z = 0; ray.t_lower = 0; ray.t_upper = 0;
    hit.ready = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls with stretches of none
  initial begin
    hit_t got;
    int gap;
    bit calm;
    sb = new();
    @(posedge clk iff !rst);
    forever begin
      calm = $urandom_range(0, 3) == 0;
      repeat (50) begin
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
          hit.ready <= 0;
          repeat (gap) @(posedge clk);
        end
        hit.ready <= 1;
        @(posedge clk);
        while (!hit.valid) @(posedge clk);
        got.found = hit.hit_found; got.t = hit.hit_t;
        got.u = hit.tex_u; got.v = hit.tex_v;
        got.p[0] = hit.point_x; got.p[1] = hit.point_y; got.p[2] = hit.point_z;
        got.front = hit.front_face; got.mat = hit.hit_material;
        sb.check_hit(got);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk iff pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_PLANE_AXIS:   axis_q = val[1:0];
      REG_PLANE_OFFSET: offset_q = 64'(signed'(val));
      REG_U_LOW:        ulo_q = 64'(signed'(val));
      REG_U_HIGH:       uhi_q = 64'(signed'(val));
      REG_V_LOW:        vlo_q = 64'(signed'(val));
      REG_V_HIGH:       vhi_q = 64'(signed'(val));
      REG_MATERIAL_ID:  mat_q = val[7:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  // one beat, with a random gap first unless calm
  task automatic send_ray(ray_t r, bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      ray.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    ray.valid <= 1;
    ray.origin_x <= r.o[0]; ray.origin_y <= r.o[1]; ray.origin_z <= r.o[2];
    ray.dir_x <= r.d[0]; ray.dir_y <= r.d[1]; ray.dir_z <= r.d[2];
    ray.t_lower <= r.tlo; ray.t_upper <= r.thi;
    @(posedge clk);
    while (!ray.ready) @(posedge clk);
    sb.note_ray(r);
  endtask

  task automatic end_burst();
    ray.valid <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [31:0] small_fix();
    return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  // mostly rays aimed into the rectangle window, the rest raw noise
  function automatic ray_t make_ray();
    ray_t r;
    int a;
    logic signed [31:0] tgt;
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 3; i++) begin r.o[i] = rnd_word(); r.d[i] = rnd_word(); end
      r.tlo = rnd_word(); r.thi = rnd_word();
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      r.o[i] = small_fix();
      r.d[i] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    end
    a = axis_q == PLANE_XY ? 2 : axis_q == PLANE_YZ ? 0 : 1;
    tgt = $signed($urandom_range(0, 32'h0003_0000));
    // pick a t, back off origin along randomly chosen in-plane axes so the hit lands near the low bounds
    for (int i = 0; i < 3; i++)
      if (i != a && $urandom_range(0, 1))
        r.o[i] = 32'((i == (a == 0 ? 1 : 0) ? ulo_q : vlo_q) +
                 $signed($urandom_range(0, 32'h0002_0000)) - 64'((tgt * r.d[i]) >>> 16));
    if ($urandom_range(0, 9) != 0) r.o[a] = 32'(offset_q - 64'((tgt * r.d[a]) >>> 16));
    r.tlo = $urandom_range(0, 3) == 0 ? small_fix() : 32'sh8000_0000;
    r.thi = $urandom_range(0, 3) == 0 ? small_fix() : 32'sh7fff_ffff;
    return r;
  endfunction

  task automatic random_config(bit wide);
    logic signed [31:0] lo, hi;
    reg_write(REG_PLANE_AXIS, $urandom_range(0, 9) == 0 ? 32'd3 : $urandom_range(0, 2));
    reg_write(REG_PLANE_OFFSET, wide ? rnd_word() : small_fix());
    lo = wide ? rnd_word() : small_fix();
    hi = wide ? rnd_word() : lo + $signed($urandom_range(0, 32'h0004_0000));
    reg_write(REG_U_LOW, lo); reg_write(REG_U_HIGH, hi);
    lo = wide ? rnd_word() : small_fix();
    hi = wide ? rnd_word() : lo + $signed($urandom_range(0, 32'h0004_0000));
    reg_write(REG_V_LOW, lo); reg_write(REG_V_HIGH, hi);
    reg_write(REG_MATERIAL_ID, $urandom_range(0, 255));
  endtask

  initial begin
    ray_t r;
    bit calm;
    axis_q = 0; offset_q = 0; ulo_q = 0; uhi_q = 65536; vlo_q = 0; vhi_q = 65536;
    mat_q = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset setting, z = 0 plane, unit square
    for (int k = 0; k < 6; k++) begin
      r.o[0] = 32'sh0000_8000; r.o[1] = 32'sh0000_8000; r.o[2] = 32'sh0001_0000;
      r.d[0] = 0; r.d[1] = 0; r.d[2] = -32'sh0001_0000;
      r.tlo = 32'sh8000_0000; r.thi = 32'sh7fff_ffff;
      case (k)
        1: r.d[2] = 0;                                      // parallel ray
        2: r.d[2] = 32'sh0001_0000;                         // back side
        3: begin r.o[0] = 32'sh0001_0000; r.o[1] = 0; end   // exact corner
        4: r.thi = 0;                                       // t beyond interval
        5: begin r.o[0] = 32'sh7fff_ffff; r.d[0] = 32'sh7fff_ffff; end // saturation
        default: ;
      endcase
      send_ray(r, 0);
    end
    end_burst();
    wait_drained();
    // extremes of every field, degenerate bounds, unused axis
    reg_write(REG_U_HIGH, 0);
    reg_write(REG_MATERIAL_ID, 8'hff);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        r.o[i] = k[0] ? 32'h7fff_ffff : 32'h8000_0000;
        r.d[i] = k[1] ? 32'h7fff_ffff : 32'h8000_0000;
      end
      r.o[0] = 0; r.o[1] = k[2] ? 0 : 32'h0000_4000;
      r.tlo = k[2] ? 32'h7fff_ffff : 32'h8000_0000; r.thi = 32'h7fff_ffff;
      send_ray(r, 1);
    end
    end_burst();
    wait_drained();
    reg_write(REG_PLANE_AXIS, 3);
    send_ray(make_ray(), 1);
    end_burst();
    wait_drained();
    reg_write(REG_PLANE_AXIS, PLANE_ZX);
    reg_write(REG_PLANE_OFFSET, 32'h8000_0000);
    reg_write(REG_U_LOW, 32'h8000_0000); reg_write(REG_U_HIGH, 32'h7fff_ffff);
    reg_write(REG_V_LOW, 32'h8000_0000); reg_write(REG_V_HIGH, 32'h7fff_ffff);
    for (int k = 0; k < 4; k++) send_ray(make_ray(), 1);
    end_burst();
    wait_drained();
    // random phases
    for (int ph = 0; ph < 20; ph++) begin
      random_config(ph % 5 == 4);
      calm = ph % 3 == 0;
      for (int k = 0; k < 100; k++) begin
        send_ray(make_ray(), calm && k < 50);
        if (k == 60 && ph == 2) begin
          end_burst();
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      end_burst();
      wait_drained();
    end
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
